/* sv/csrg_pkg.sv */
`default_nettype none

package csrg_pkg;

    localparam int VERTICES = 1024;
    localparam int EDGES    = 4096;

    localparam int VTX_W  = $clog2(VERTICES);
    localparam int EA_W   = $clog2(EDGES);
    localparam int CNT_W  = $clog2(EDGES + 1);
    localparam int EDGE_W = 2 * VTX_W;

    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BUILD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // write request into the row table (start offset and degree per vertex)
    typedef struct packed {
        logic             we;
        logic [VTX_W-1:0] addr;
        logic [CNT_W-1:0] start;
        logic [CNT_W-1:0] deg;
    } csrg_row_wr_t;

    // write request into the flat neighbor array
    typedef struct packed {
        logic             we;
        logic [EA_W-1:0]  addr;
        logic [VTX_W-1:0] data;
    } csrg_flat_wr_t;

    typedef struct packed {
        logic [VTX_W-1:0]  neighbor_out;
        logic [CNT_W-1:0]  start_offset;
        logic [CNT_W-1:0]  degree;
        logic [STAT_W-1:0] status;
    } csrg_res_t;

endpackage

`default_nettype wire

/* sv/csrg_req_if.sv */
`default_nettype none

interface csrg_req_if import csrg_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [VTX_W-1:0]  vertex;
    logic [VTX_W-1:0]  neighbor;
    logic [EA_W-1:0]   slot;

    modport source (output valid, command, vertex, neighbor, slot, input ready);
    modport sink   (input valid, command, vertex, neighbor, slot, output ready);
endinterface

`default_nettype wire

/* sv/csrg_rsp_if.sv */
`default_nettype none

interface csrg_rsp_if import csrg_pkg::*;;
    logic              valid;
    logic              ready;
    logic [VTX_W-1:0]  neighbor_out;
    logic [CNT_W-1:0]  start_offset;
    logic [CNT_W-1:0]  degree;
    logic [STAT_W-1:0] status;

    modport source (output valid, neighbor_out, start_offset, degree, status, input ready);
    modport sink   (input valid, neighbor_out, start_offset, degree, status, output ready);
endinterface

`default_nettype wire

/* sv/csrg_ram.sv */
`default_nettype none

module csrg_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* sv/csrg_build.sv */
`default_nettype none

module csrg_build import csrg_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [CNT_W-1:0]  edge_count,
    output logic      [EA_W-1:0]   edge_raddr,
    input  wire logic [EDGE_W-1:0] edge_rdata,
    output csrg_row_wr_t           row_wr,
    output csrg_flat_wr_t          flat_wr,
    output logic                   done
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] B_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] B_CLR   = 4'd1;
    localparam logic [ST_W-1:0] B_CNT_E = 4'd2;
    localparam logic [ST_W-1:0] B_CNT_C = 4'd3;
    localparam logic [ST_W-1:0] B_CNT_W = 4'd4;
    localparam logic [ST_W-1:0] B_PRE_R = 4'd5;
    localparam logic [ST_W-1:0] B_PRE_W = 4'd6;
    localparam logic [ST_W-1:0] B_SCT_E = 4'd7;
    localparam logic [ST_W-1:0] B_SCT_C = 4'd8;
    localparam logic [ST_W-1:0] B_SCT_W = 4'd9;
    localparam logic [ST_W-1:0] B_DONE  = 4'd10;

    localparam logic [VTX_W-1:0] V_LAST = VTX_W'(VERTICES - 1);

    logic [ST_W-1:0]  state_reg, state_next;
    logic [VTX_W-1:0] v_reg, v_next;
    logic [EA_W-1:0]  e_reg, e_next;
    logic [CNT_W-1:0] run_reg, run_next;
    logic [VTX_W-1:0] src_reg, src_next;
    logic [VTX_W-1:0] tgt_reg, tgt_next;

    // count / cursor memory, one entry per vertex
    logic             cnt_we;
    logic [VTX_W-1:0] cnt_waddr;
    logic [CNT_W-1:0] cnt_wdata;
    logic [VTX_W-1:0] cnt_raddr;
    logic [CNT_W-1:0] cnt_rdata;

    logic [VTX_W-1:0] e_src;
    logic [VTX_W-1:0] e_tgt;
    logic             e_last;
    logic [CNT_W-1:0] cnt_inc;

    csrg_ram #(
        .DEPTH (VERTICES),
        .WIDTH (CNT_W)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    assign edge_raddr = e_reg;
    assign e_src      = edge_rdata[EDGE_W-1:VTX_W];
    assign e_tgt      = edge_rdata[VTX_W-1:0];
    assign e_last     = ({1'b0, e_reg} + CNT_W'(1)) == edge_count;
    assign cnt_inc    = cnt_rdata + CNT_W'(1);
    assign cnt_raddr  = (state_reg == B_PRE_R) ? v_reg : e_src;
    assign done       = (state_reg == B_DONE);

    always_comb
    begin
        state_next = state_reg;
        v_next     = v_reg;
        e_next     = e_reg;
        run_next   = run_reg;
        src_next   = src_reg;
        tgt_next   = tgt_reg;
        cnt_we     = 1'b0;
        cnt_waddr  = v_reg;
        cnt_wdata  = '0;
        row_wr     = '0;
        flat_wr    = '0;

        case (state_reg)
            B_IDLE:
            begin
                if (start)
                begin
                    v_next     = '0;
                    state_next = B_CLR;
                end
            end
            B_CLR:
            begin
                cnt_we = 1'b1;
                v_next = v_reg + VTX_W'(1);
                if (v_reg == V_LAST)
                begin
                    e_next     = '0;
                    state_next = (edge_count != '0) ? B_CNT_E : B_PRE_R;
                end
            end
            B_CNT_E:
            begin
                state_next = B_CNT_C;
            end
            B_CNT_C:
            begin
                src_next   = e_src;
                state_next = B_CNT_W;
            end
            B_CNT_W:
            begin
                // the next edge reads this vertex's count only after this write has landed
                cnt_we    = 1'b1;
                cnt_waddr = src_reg;
                cnt_wdata = cnt_inc;
                e_next    = e_reg + EA_W'(1);
                state_next = e_last ? B_PRE_R : B_CNT_E;
            end
            B_PRE_R:
            begin
                state_next = B_PRE_W;
            end
            B_PRE_W:
            begin
                row_wr.we    = 1'b1;
                row_wr.addr  = v_reg;
                row_wr.start = run_reg;
                row_wr.deg   = cnt_rdata;
                cnt_we       = 1'b1;
                cnt_wdata    = run_reg;
                run_next     = run_reg + cnt_rdata;
                v_next       = v_reg + VTX_W'(1);
                if (v_reg == V_LAST)
                begin
                    e_next     = '0;
                    state_next = (edge_count != '0) ? B_SCT_E : B_DONE;
                end
                else
                begin
                    state_next = B_PRE_R;
                end
            end
            B_SCT_E:
            begin
                state_next = B_SCT_C;
            end
            B_SCT_C:
            begin
                src_next   = e_src;
                tgt_next   = e_tgt;
                state_next = B_SCT_W;
            end
            B_SCT_W:
            begin
                flat_wr.we   = (cnt_rdata < CNT_W'(EDGES));
                flat_wr.addr = cnt_rdata[EA_W-1:0];
                flat_wr.data = tgt_reg;
                cnt_we       = 1'b1;
                cnt_waddr    = src_reg;
                cnt_wdata    = cnt_inc;
                e_next       = e_reg + EA_W'(1);
                state_next   = e_last ? B_DONE : B_SCT_E;
            end
            B_DONE:
            begin
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            v_reg     <= '0;
            e_reg     <= '0;
            run_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            v_reg     <= v_next;
            e_reg     <= e_next;
            run_reg   <= (state_reg == B_CLR) ? '0 : run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        tgt_reg <= tgt_next;
    end

endmodule

`default_nettype wire

/* sv/csr_graph_builder.sv */
// results: append, build-less rejects and failed queries/reads go from accept straight to the
//   result register; a successful query or read first waits in S_MEM for one memory read
// build: runs on the count/cursor ram port in order: a clear of every vertex, a count step
//   per edge, a prefix step per vertex and a scatter step per edge
// requests: one at a time; a new one is taken only after the previous result is registered
// reset: control, edge count and built mark cleared; memories hold no reset value
`default_nettype none

module csr_graph_builder import csrg_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    csrg_req_if.sink    req,
    csrg_rsp_if.source  rsp
);

    // top-level request sequencer
    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] S_IDLE  = 2'd0;
    localparam logic [ST_W-1:0] S_MEM   = 2'd1;
    localparam logic [ST_W-1:0] S_BUILD = 2'd2;
    localparam logic [ST_W-1:0] S_DONE  = 2'd3;

    logic [ST_W-1:0]  state_reg, state_next;
    logic [CNT_W-1:0] edge_count_reg, edge_count_next;
    logic             built_reg, built_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    csrg_res_t        res_reg, res_next;
    csrg_res_t        out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic             accept;
    logic             store_full;
    logic             out_free;

    // edge store: {source, destination} in append order
    logic              edge_we;
    logic [EDGE_W-1:0] edge_wdata;
    logic [EA_W-1:0]   edge_raddr;
    logic [EDGE_W-1:0] edge_rdata;

    // row table {start, degree} and flat neighbor array, written only by the build engine
    csrg_row_wr_t      row_wr;
    csrg_flat_wr_t     flat_wr;
    logic [2*CNT_W-1:0] row_rdata;
    logic [VTX_W-1:0]  flat_rdata;

    logic              bld_start;
    logic              bld_done;

    assign accept     = req.valid && req.ready;
    assign req.ready  = (state_reg == S_IDLE);
    assign store_full = (edge_count_reg == CNT_W'(EDGES));
    assign out_free   = !out_valid_reg || rsp.ready;

    assign edge_we    = accept && (req.command == CMD_APPEND) && !store_full;
    assign edge_wdata = {req.vertex, req.neighbor};
    assign bld_start  = accept && (req.command == CMD_BUILD);

    csrg_ram #(
        .DEPTH (EDGES),
        .WIDTH (EDGE_W)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_count_reg[EA_W-1:0]),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    // the row table's read data is used only after a build has rewritten every entry,
    // so its contents, which have no reset value, need no clearing pass
    csrg_ram #(
        .DEPTH (VERTICES),
        .WIDTH (2 * CNT_W)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_wr.we),
        .waddr (row_wr.addr),
        .wdata ({row_wr.start, row_wr.deg}),
        .raddr (req.vertex),
        .rdata (row_rdata)
    );

    csrg_ram #(
        .DEPTH (EDGES),
        .WIDTH (VTX_W)
    ) u_flat_ram (
        .clk   (clk),
        .we    (flat_wr.we),
        .waddr (flat_wr.addr),
        .wdata (flat_wr.data),
        .raddr (req.slot),
        .rdata (flat_rdata)
    );

    csrg_build u_build (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (bld_start),
        .edge_count (edge_count_reg),
        .edge_raddr (edge_raddr),
        .edge_rdata (edge_rdata),
        .row_wr     (row_wr),
        .flat_wr    (flat_wr),
        .done       (bld_done)
    );

    always_comb
    begin
        state_next      = state_reg;
        edge_count_next = edge_count_reg;
        built_next      = built_reg;
        cmd_next        = cmd_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;

        // response register drains independently of the sequencer
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = req.command;
                    res_next = '0;
                    case (req.command)
                        CMD_APPEND:
                        begin
                            // any append invalidates the built graph, dropped or not
                            built_next = 1'b0;
                            if (store_full)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                edge_count_next = edge_count_reg + CNT_W'(1);
                            end
                            state_next = S_DONE;
                        end
                        CMD_BUILD:
                        begin
                            state_next = S_BUILD;
                        end
                        CMD_QUERY:
                        begin
                            if (!built_reg)
                            begin
                                res_next.status = ST_RANGE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_MEM;
                            end
                        end
                        CMD_READ:
                        begin
                            if (!built_reg || ({1'b0, req.slot} >= edge_count_reg))
                            begin
                                res_next.status = ST_RANGE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_MEM;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_MEM:
            begin
                // read data for the address presented at accept is here now
                if (cmd_reg == CMD_QUERY)
                begin
                    res_next.start_offset = row_rdata[2*CNT_W-1:CNT_W];
                    res_next.degree       = row_rdata[CNT_W-1:0];
                end
                else
                begin
                    res_next.neighbor_out = flat_rdata;
                end
                res_next.status = ST_OK;
                state_next      = S_DONE;
            end
            S_BUILD:
            begin
                if (bld_done)
                begin
                    built_next = 1'b1;
                    res_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            edge_count_reg <= '0;
            built_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_count_reg <= edge_count_next;
            built_reg      <= built_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.neighbor_out = out_reg.neighbor_out;
    assign rsp.start_offset = out_reg.start_offset;
    assign rsp.degree       = out_reg.degree;
    assign rsp.status       = out_reg.status;

endmodule

`default_nettype wire

/* verif/csr_graph_builder_tb.sv */
`timescale 1ns / 100ps

// checks csr_graph_builder against an in-bench model of the edge store and the csr tables
module csr_graph_builder_tb;
    import csrg_pkg::*;

    localparam int RANDOM_ITEMS = 1590;
    // a build over a full edge store is the longest stretch without a handshake; the limit must cover it
    localparam int QUIET_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [VTX_W-1:0] vertex;
        logic [VTX_W-1:0] neighbor;
        logic [EA_W-1:0]  slot;
    } graph_req_t;

    // handshake pressure, cycled between request batches
    typedef enum {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    csrg_req_if req_ch ();
    csrg_rsp_if rsp_ch ();

    csr_graph_builder DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // graph model: edge store in append order, row starts and flat array
    // ------------------------------------------------------------------
    logic [VTX_W-1:0] edge_src  [EDGES];
    logic [VTX_W-1:0] edge_dst  [EDGES];
    logic [CNT_W-1:0] row_start [VERTICES+1];
    logic [VTX_W-1:0] flat_nbr  [EDGES];
    int               stored_edges = 0;
    bit               graph_built  = 1'b0;

    // request streams and the responses they should produce
    graph_req_t cmd_queue [$];
    csrg_res_t  pending_rsp [$];

    pace_t pace           = PACE_BOTH;
    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;
    int    gen_edges      = 0;  // edges the queued appends will have stored
    int    queued_total   = 0;
    int    accepted_total = 0;
    int    quiet_cycles   = 0;
    int    mismatches     = 0;

    // applies one request to the graph model and returns the response it gives
    function automatic csrg_res_t csr_response(graph_req_t r);
        csrg_res_t        res;
        logic [CNT_W-1:0] cursor [VERTICES];
        int               src;
        res = '0;
        res.status = ST_OK;
        case (r.command)
            CMD_APPEND:
            begin
                // any append drops the built mark, even one that is refused;
                // every 10-bit source is a valid vertex, so only a full store refuses
                graph_built = 1'b0;
                if (stored_edges >= EDGES)
                    res.status = ST_FULL;
                else
                begin
                    edge_src[stored_edges] = r.vertex;
                    edge_dst[stored_edges] = r.neighbor;
                    stored_edges++;
                end
            end
            CMD_BUILD:
            begin
                // counting sort: out-degrees one place right, prefix sums, then scatter
                for (int v = 0; v <= VERTICES; v++)
                    row_start[v] = '0;
                for (int e = 0; e < stored_edges; e++)
                begin
                    src = int'(edge_src[e]) + 1;
                    row_start[src] = row_start[src] + 1'b1;
                end
                for (int v = 0; v < VERTICES; v++)
                    row_start[v+1] = row_start[v+1] + row_start[v];
                for (int v = 0; v < VERTICES; v++)
                    cursor[v] = row_start[v];
                // append order is kept inside each vertex's row
                for (int e = 0; e < stored_edges; e++)
                begin
                    flat_nbr[cursor[edge_src[e]]] = edge_dst[e];
                    cursor[edge_src[e]] = cursor[edge_src[e]] + 1'b1;
                end
                graph_built = 1'b1;
            end
            CMD_QUERY:
            begin
                if (!graph_built)
                    res.status = ST_RANGE;
                else
                begin
                    res.start_offset = row_start[r.vertex];
                    res.degree       = row_start[int'(r.vertex) + 1] - row_start[r.vertex];
                end
            end
            default:
            begin
                // read: only slots below the stored edge count hold data
                if (!graph_built || r.slot >= stored_edges)
                    res.status = ST_RANGE;
                else
                    res.neighbor_out = flat_nbr[r.slot];
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_req(logic [CMD_W-1:0] command, logic [VTX_W-1:0] vertex,
                                      logic [VTX_W-1:0] neighbor, logic [EA_W-1:0] slot);
        graph_req_t r;
        r.command  = command;
        r.vertex   = vertex;
        r.neighbor = neighbor;
        r.slot     = slot;
        cmd_queue = {cmd_queue, r};
        queued_total++;
        if (command == CMD_APPEND && gen_edges < EDGES)
            gen_edges++;
    endfunction

    // vertices cluster on a small hot set so rows get real degrees
    function automatic logic [VTX_W-1:0] pick_vertex();
        case ($urandom_range(9))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return VTX_W'($urandom_range(31));
            default:    return VTX_W'($urandom());
        endcase
    endfunction

    // slots mostly inside the stored edges, some just past the end or anywhere
    function automatic logic [EA_W-1:0] pick_slot();
        case ($urandom_range(9))
            0:       return EA_W'(gen_edges);
            1:       return '1;
            2:       return EA_W'($urandom());
            default: return (gen_edges == 0) ? '0 : EA_W'($urandom_range(gen_edges - 1));
        endcase
    endfunction

    // let the queued requests go out, then move to the next pressure setting
    task automatic next_pace();
        while (cmd_queue.size() != 0)
            @(posedge clk);
        case (pace)
            PACE_FREE:
            begin
                pace = PACE_SEND_IDLE;
                send_idle_pct = 59;
                recv_stall_pct = 0;
            end
            PACE_SEND_IDLE:
            begin
                pace = PACE_RECV_STALL;
                send_idle_pct = 0;
                recv_stall_pct = 59;
            end
            PACE_RECV_STALL:
            begin
                pace = PACE_BOTH;
                send_idle_pct = 31;
                recv_stall_pct = 31;
            end
            default:
            begin
                pace = PACE_FREE;
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // request driver: holds a request until taken, idles at random
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        graph_req_t taken;
        graph_req_t nxt;
        csrg_res_t  predicted;
        if (!rst_n)
        begin
            req_ch.valid    <= 1'b0;
            req_ch.command  <= CMD_APPEND;
            req_ch.vertex   <= '0;
            req_ch.neighbor <= '0;
            req_ch.slot     <= '0;
        end
        else
        begin
            // predict at acceptance so the model sees requests in block order
            if (req_ch.valid && req_ch.ready)
            begin
                taken.command  = req_ch.command;
                taken.vertex   = req_ch.vertex;
                taken.neighbor = req_ch.neighbor;
                taken.slot     = req_ch.slot;
                predicted = csr_response(taken);
                pending_rsp = {pending_rsp, predicted};
                accepted_total++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = cmd_queue.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.command  <= nxt.command;
                    req_ch.vertex   <= nxt.vertex;
                    req_ch.neighbor <= nxt.neighbor;
                    req_ch.slot     <= nxt.slot;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // response monitor: random back-pressure, in-order field compare
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        csrg_res_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $error("response with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp_ch.neighbor_out !== want.neighbor_out)
                    begin
                        $error("neighbor_out: expected %0d, got %0d",
                               want.neighbor_out, rsp_ch.neighbor_out);
                        mismatches++;
                    end
                    if (rsp_ch.start_offset !== want.start_offset)
                    begin
                        $error("start_offset: expected %0d, got %0d",
                               want.start_offset, rsp_ch.start_offset);
                        mismatches++;
                    end
                    if (rsp_ch.degree !== want.degree)
                    begin
                        $error("degree: expected %0d, got %0d", want.degree, rsp_ch.degree);
                        mismatches++;
                    end
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        mismatches++;
                    end
                end
            end
        end
    end

    // no handshake on either side for too long means the block hung
    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int n_app;
        int n_mix;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        next_pace();
        // before any build: query and read are refused
        queue_req(CMD_QUERY, '0, '0, '0);
        queue_req(CMD_READ, '0, '0, '0);
        // build over an empty store gives an all-zero table
        queue_req(CMD_BUILD, '0, '0, '0);
        queue_req(CMD_QUERY, '1, '0, '0);
        queue_req(CMD_READ, '0, '0, '0);
        // extreme sources and destinations
        queue_req(CMD_APPEND, '0, '1, '0);
        queue_req(CMD_APPEND, '1, '0, '1);
        queue_req(CMD_APPEND, '0, '0, '0);
        queue_req(CMD_APPEND, '1, '1, '1);
        // the appends dropped the built mark
        queue_req(CMD_QUERY, '0, '0, '0);
        queue_req(CMD_READ, '0, '0, '0);
        queue_req(CMD_BUILD, '1, '1, '1);
        queue_req(CMD_QUERY, '0, '1, '1);
        queue_req(CMD_QUERY, '1, '0, '0);
        queue_req(CMD_QUERY, VTX_W'(VERTICES / 2), '0, '0);
        // rows keep append order
        queue_req(CMD_READ, '1, '1, EA_W'(0));
        queue_req(CMD_READ, '0, '0, EA_W'(1));
        queue_req(CMD_READ, '0, '0, EA_W'(2));
        queue_req(CMD_READ, '0, '0, EA_W'(3));
        // one past the last edge, and the top slot
        queue_req(CMD_READ, '0, '0, EA_W'(4));
        queue_req(CMD_READ, '0, '0, '1);
        // a repeated build changes nothing
        queue_req(CMD_BUILD, '0, '0, '0);
        queue_req(CMD_QUERY, '1, '0, '0);

        // random sessions: a burst of appends, usually a build, then queries and reads,
        // with stray appends and builds mixed in
        while (queued_total < RANDOM_ITEMS)
        begin
            next_pace();
            n_app = $urandom_range(40);
            repeat (n_app)
                queue_req(CMD_APPEND, pick_vertex(), pick_vertex(), EA_W'($urandom()));
            // now and then skip the build so lookups hit an unbuilt graph
            if ($urandom_range(9) != 0)
                queue_req(CMD_BUILD, pick_vertex(), pick_vertex(), EA_W'($urandom()));
            n_mix = $urandom_range(4, 40);
            repeat (n_mix)
            begin
                case ($urandom_range(19))
                    0:
                        queue_req(CMD_APPEND, pick_vertex(), pick_vertex(), EA_W'($urandom()));
                    1:
                        queue_req(CMD_BUILD, pick_vertex(), pick_vertex(), EA_W'($urandom()));
                    2, 3, 4, 5, 6, 7, 8, 9, 10:
                        queue_req(CMD_QUERY, pick_vertex(), pick_vertex(), EA_W'($urandom()));
                    default:
                        queue_req(CMD_READ, pick_vertex(), pick_vertex(), pick_slot());
                endcase
            end
        end

        // lookups on the last graph, then an append drops the built mark again before a rebuild
        next_pace();
        repeat (30)
        begin
            if ($urandom_range(1) != 0)
                queue_req(CMD_QUERY, pick_vertex(), pick_vertex(), EA_W'($urandom()));
            else
                queue_req(CMD_READ, pick_vertex(), pick_vertex(), pick_slot());
        end
        queue_req(CMD_APPEND, '0, '0, '0);
        queue_req(CMD_READ, '0, '0, '1);
        queue_req(CMD_BUILD, '1, '1, '1);
        queue_req(CMD_READ, '0, '0, '1);
        queue_req(CMD_QUERY, '0, '0, '0);

        // every request taken and answered, then a short settle
        while (accepted_total != queued_total || pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
sv/csrg_pkg.sv
sv/csrg_req_if.sv
sv/csrg_rsp_if.sv
sv/csrg_ram.sv
sv/csrg_build.sv
sv/csr_graph_builder.sv
verif/csr_graph_builder_tb.sv
